// ===== rtl/elru_pkg.sv =====
// Types and constants for the emergency registry table.
// Holds the report and result beats, the scan accumulator and the cell write command.
// No dependencies.
package elru_pkg;

	localparam int ORIGIN_W = 32;
	localparam int CODE_W   = 8;
	localparam int STAMP_W  = 32;
	localparam int ACTION_W = 3;
	localparam int SLOT_W   = 3;
	localparam int IDX_W    = 6;

	localparam logic [CODE_W-1:0]  CODE_NONE   = 8'd0;
	localparam logic [CODE_W-1:0]  CODE_FINISH = 8'd255;
	localparam logic [STAMP_W-1:0] STAMP_MAX   = 32'hFFFF_FFFF;

	localparam logic [ACTION_W-1:0] ACT_IGNORED  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_UPDATED  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INSERTED = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_EVICTED  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_REMOVED  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_MISSED   = 3'd5;

	typedef struct packed {
		logic [ORIGIN_W-1:0] origin;
		logic [CODE_W-1:0]   code;
	} report_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [SLOT_W-1:0]   slot;
		logic [ORIGIN_W-1:0] evicted_origin;
		logic [CODE_W-1:0]   hint_code;
		logic [ORIGIN_W-1:0] hint_origin;
	} result_t;

	typedef struct packed {
		logic                hit;
		logic [IDX_W-1:0]    hit_idx;
		logic                free;
		logic [IDX_W-1:0]    free_idx;
		logic [IDX_W-1:0]    old_idx;
		logic [STAMP_W-1:0]  min_stamp;
		logic [ORIGIN_W-1:0] old_origin;
	} scan_acc_t;

	typedef struct packed {
		logic                we;
		logic                clear;
		logic [IDX_W-1:0]    idx;
		logic [ORIGIN_W-1:0] origin;
		logic [CODE_W-1:0]   code;
		logic [STAMP_W-1:0]  stamp;
	} cell_wr_t;

endpackage

// ===== rtl/elru_chan_if.sv =====
// Valid/ready channel carrying one beat of a packed payload type.
// Depends on nothing; the payload type is given at instantiation.
interface elru_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/emergency_registry_lru_table.sv =====
// Emergency registry: fully associative table of emergency reports keyed by origin.
// Chain of elru_cell entries scanned one per cycle; depends on elru_pkg, elru_chan_if.
//
// Use:
//   req carries one report beat (origin, code); rsp carries one result beat
//   (action, slot, evicted_origin, hint_code, hint_origin) per report.
//   A report is taken when the block is idle; the scan then visits one cell per cycle,
//   and the commit state writes the chosen cell and loads the result register. The
//   result beat is presented from that register. A new report is taken only after
//   the commit of the last one, once the block is back in idle.
//   The result register lets the next report be taken and scanned while a result
//   waits; if rsp is still stalled at commit, the block holds in commit until the
//   result is taken.
//   Reset clears every entry, the stamp counter and the hint; no clearing pass is
//   needed, so a report can be taken as soon as reset is released.
module emergency_registry_lru_table import elru_pkg::*; #(
	parameter int TABLE_ENTRIES = 8
) (
	input logic                        clk,
	input logic                        arst_n,
	elru_chan_if.sink                  req,
	elru_chan_if.source                rsp
);

	localparam int CNT_W = $clog2(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	report_t             rep_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [CODE_W-1:0]   last_code_q;
	logic [ORIGIN_W-1:0] last_origin_q;
	result_t             rsp_q;
	logic                rsp_valid_q;

	scan_acc_t           acc [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] cell_en;
	cell_wr_t            wr;
	result_t             res;
	logic [STAMP_W-1:0]  stamp_next;
	logic                req_fire;
	logic                commit_fire;
	logic                bump;
	scan_acc_t           fin;

	assign req.ready   = (state_q == ST_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign commit_fire = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp.ready);
	assign stamp_next  = stamp_q + STAMP_W'(1);
	assign fin         = acc[TABLE_ENTRIES];

	always_comb begin
		acc[0]            = '0;
		acc[0].min_stamp  = STAMP_MAX;
	end

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			assign cell_en[gi] = (state_q == ST_SCAN) && (cnt_q == CNT_W'(gi));
			elru_cell #(.CELL_IDX(gi)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (cell_en[gi]),
				.key    (rep_q.origin),
				.acc_i  (acc[gi]),
				.acc_o  (acc[gi+1]),
				.wr     (wr)
			);
		end
	endgenerate

	always_comb begin
		wr        = '0;
		wr.origin = rep_q.origin;
		wr.code   = rep_q.code;
		wr.stamp  = stamp_next;
		res       = '0;
		bump      = 1'b0;
		if (last_code_q != CODE_NONE && last_origin_q != '0) begin
			res.hint_code   = last_code_q;
			res.hint_origin = last_origin_q;
		end
		if (rep_q.code == CODE_FINISH) begin
			if (fin.hit) begin
				wr.we      = commit_fire;
				wr.clear   = 1'b1;
				wr.idx     = fin.hit_idx;
				res.action = ACT_REMOVED;
				res.slot   = fin.hit_idx[SLOT_W-1:0];
			end else begin
				res.action = ACT_MISSED;
			end
		end else if (rep_q.code != CODE_NONE) begin
			wr.we = commit_fire;
			bump  = 1'b1;
			if (fin.hit) begin
				wr.idx     = fin.hit_idx;
				res.action = ACT_UPDATED;
			end else if (fin.free) begin
				wr.idx     = fin.free_idx;
				res.action = ACT_INSERTED;
			end else begin
				wr.idx             = fin.old_idx;
				res.action         = ACT_EVICTED;
				res.evicted_origin = fin.old_origin;
			end
			res.slot = wr.idx[SLOT_W-1:0];
		end else begin
			res.action = ACT_IGNORED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			stamp_q       <= '0;
			last_code_q   <= '0;
			last_origin_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_COMMIT: begin
					if (commit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit_fire) begin
				rsp_valid_q <= 1'b1;
				if (bump) begin
					stamp_q <= stamp_next;
				end
				if (rep_q.code == CODE_FINISH || rep_q.code == CODE_NONE) begin
					last_code_q   <= '0;
					last_origin_q <= '0;
				end else begin
					last_code_q   <= rep_q.code;
					last_origin_q <= rep_q.origin;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rep_q <= req.data;
		end
		if (commit_fire) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_scan_one_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_en))
		else $error("more than one cell scanning");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("accepted beat did not start the scan");

	a_commit_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit_fire |=> rsp_valid_q)
		else $error("commit did not load the result register");

	a_stamp_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_fire && (res.action == ACT_UPDATED || res.action == ACT_INSERTED ||
		res.action == ACT_EVICTED)) |=> (stamp_q == $past(stamp_q) + STAMP_W'(1)))
		else $error("stamp did not advance on table write");

	a_stamp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit_fire |=> $stable(stamp_q))
		else $error("stamp moved outside commit");

endmodule

// ===== rtl/elru_cell.sv =====
// One table entry with its stage of the lookup/victim scan.
// Depends on elru_pkg.
module elru_cell import elru_pkg::*; #(
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [ORIGIN_W-1:0] key,
	input  scan_acc_t           acc_i,
	output scan_acc_t           acc_o,
	input  cell_wr_t            wr
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                valid_q;
	logic [ORIGIN_W-1:0] origin_q;
	logic [CODE_W-1:0]   code_q;
	logic [STAMP_W-1:0]  stamp_q;
	scan_acc_t           acc_d;
	scan_acc_t           acc_q;
	logic                older;

	always_comb begin
		acc_d = acc_i;
		older = valid_q && (stamp_q < acc_i.min_stamp);
		if (!acc_i.hit && valid_q && origin_q == key) begin
			acc_d.hit     = 1'b1;
			acc_d.hit_idx = MY_IDX;
		end
		if (!acc_i.free && !valid_q) begin
			acc_d.free     = 1'b1;
			acc_d.free_idx = MY_IDX;
		end
		if (older) begin
			acc_d.min_stamp = stamp_q;
			acc_d.old_idx   = MY_IDX;
		end
		if (older || CELL_IDX == 0) begin
			acc_d.old_origin = origin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			origin_q <= '0;
			code_q   <= '0;
			stamp_q  <= '0;
		end else if (wr.we && wr.idx == MY_IDX) begin
			if (wr.clear) begin
				valid_q <= 1'b0;
			end else begin
				valid_q  <= 1'b1;
				origin_q <= wr.origin;
				code_q   <= wr.code;
				stamp_q  <= wr.stamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= acc_d;
		end
	end

	assign acc_o = acc_q;

endmodule
